@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared widths, opcodes, pipeline beat type and saturation helper for the
// Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int OP_W      = 4;

   localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
   localparam logic [OP_W-1:0] OP_LT   = 4'd4;
   localparam logic [OP_W-1:0] OP_GT   = 4'd5;
   localparam logic [OP_W-1:0] OP_LE   = 4'd6;
   localparam logic [OP_W-1:0] OP_GE   = 4'd7;
   localparam logic [OP_W-1:0] OP_EQ   = 4'd8;
   localparam logic [OP_W-1:0] OP_NE   = 4'd9;
   localparam logic [OP_W-1:0] OP_INC  = 4'd10;
   localparam logic [OP_W-1:0] OP_DEC  = 4'd11;
   localparam logic [OP_W-1:0] OP_MIN  = 4'd12;
   localparam logic [OP_W-1:0] OP_MAX  = 4'd13;
   localparam logic [OP_W-1:0] OP_FROM = 4'd14;
   localparam logic [OP_W-1:0] OP_TOI  = 4'd15;

   localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] res;
      logic                     cmp;
      logic                     dz;
      logic                     neg;
      logic signed [PROD_W-1:0] prod;
      logic [DATA_W-1:0]        rem;
      logic [NUM_W-1:0]         num;
      logic [DATA_W-1:0]        den;
   } beat_type;

   function automatic logic signed [DATA_W-1:0] sat_mag(
      input logic [PROD_W-1:0] mag,
      input logic              neg
   );
      logic big;
      big = (mag >= (PROD_W'(1) << (DATA_W-1)));
      if (neg) begin
         sat_mag = big ? S_MIN : -$signed(mag[DATA_W-1:0]);
      end else begin
         sat_mag = big ? S_MAX : $signed(mag[DATA_W-1:0]);
      end
   endfunction

endpackage

@@ rtl/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// Decode stage: simple operations, compares, product and divider setup.
// ----------------------------------------------------------------------------
module fpa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [fpa_pkg::OP_W-1:0]      in_op,
   input  logic signed [fpa_pkg::DATA_W-1:0] in_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] in_b,
   output logic                          out_valid,
   input  logic                          out_ready,
   output fpa_pkg::beat_type             out_beat
);
   import fpa_pkg::*;

   logic                     valid_ff;
   beat_type                 beat_ff;
   beat_type                 beat_in;
   logic signed [DATA_W:0]   sum;
   logic signed [DATA_W:0]   dif;
   logic signed [NUM_W-1:0]  wide;
   logic [DATA_W-1:0]        mag_a;
   logic                     lt;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      sum   = (DATA_W+1)'(in_a) + (DATA_W+1)'(in_b);
      dif   = (DATA_W+1)'(in_a) - (DATA_W+1)'(in_b);
      wide  = NUM_W'(in_a) <<< FRAC_BITS;
      lt    = in_a < in_b;
      mag_a = in_a[DATA_W-1] ? DATA_W'(-in_a) : DATA_W'(in_a);
      beat_in      = '0;
      beat_in.op   = in_op;
      beat_in.prod = PROD_W'(in_a) * PROD_W'(in_b);
      beat_in.num  = {mag_a, {FRAC_BITS{1'b0}}};
      beat_in.den  = in_b[DATA_W-1] ? DATA_W'(-in_b) : DATA_W'(in_b);
      beat_in.neg  = (in_op == OP_DIV) ? (in_a[DATA_W-1] ^ in_b[DATA_W-1])
                                       : 1'b0;
      unique case (in_op)
         OP_ADD: beat_in.res = (sum > (DATA_W+1)'(S_MAX)) ? S_MAX :
                               (sum < (DATA_W+1)'(S_MIN)) ? S_MIN : sum[DATA_W-1:0];
         OP_SUB: beat_in.res = (dif > (DATA_W+1)'(S_MAX)) ? S_MAX :
                               (dif < (DATA_W+1)'(S_MIN)) ? S_MIN : dif[DATA_W-1:0];
         OP_DIV: begin
            beat_in.dz  = (in_b == '0);
            beat_in.res = in_a[DATA_W-1] ? S_MIN : S_MAX;
         end
         OP_LT: beat_in.cmp = lt;
         OP_GT: beat_in.cmp = in_a > in_b;
         OP_LE: beat_in.cmp = !(in_a > in_b);
         OP_GE: beat_in.cmp = !lt;
         OP_EQ: beat_in.cmp = (in_a == in_b);
         OP_NE: beat_in.cmp = (in_a != in_b);
         OP_INC: beat_in.res = (in_a == S_MAX) ? S_MAX : in_a + DATA_W'(1);
         OP_DEC: beat_in.res = (in_a == S_MIN) ? S_MIN : in_a - DATA_W'(1);
         OP_MIN: beat_in.res = lt ? in_a : in_b;
         OP_MAX: beat_in.res = (in_a > in_b) ? in_a : in_b;
         OP_FROM: beat_in.res = (wide > NUM_W'(S_MAX)) ? S_MAX :
                                (wide < NUM_W'(S_MIN)) ? S_MIN : wide[DATA_W-1:0];
         OP_TOI: beat_in.res = in_a >>> FRAC_BITS;
         default: beat_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

endmodule

@@ rtl/fpa_div_cell.sv @@
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring divide step per cell; hands the beat to its neighbor.
// ----------------------------------------------------------------------------
module fpa_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpa_pkg::beat_type in_beat,
   output logic              out_valid,
   input  logic              out_ready,
   output fpa_pkg::beat_type out_beat
);
   import fpa_pkg::*;

   logic          valid_ff;
   beat_type      beat_ff;
   beat_type      beat_in;
   logic [DATA_W:0] trial;
   logic          fits;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      trial   = {in_beat.rem, in_beat.num[NUM_W-1]};
      fits    = (trial >= {1'b0, in_beat.den});
      beat_in = in_beat;
      beat_in.rem = fits ? DATA_W'(trial - {1'b0, in_beat.den}) : trial[DATA_W-1:0];
      beat_in.num = {in_beat.num[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

endmodule

@@ rtl/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// Output stage: rounds and saturates multiply and divide, holds the result.
// ----------------------------------------------------------------------------
module fpa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  fpa_pkg::beat_type                 in_beat,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [fpa_pkg::DATA_W-1:0] out_res,
   output logic                              out_cmp,
   output logic                              out_dz
);
   import fpa_pkg::*;

   logic                     valid_ff;
   logic signed [DATA_W-1:0] res_ff;
   logic                     cmp_ff;
   logic                     dz_ff;
   logic signed [DATA_W-1:0] res_in;
   logic [PROD_W-1:0]        pmag;
   logic [PROD_W-1:0]        pq;
   logic [PROD_W-1:0]        dq;
   logic                     up;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_cmp   = cmp_ff;
   assign out_dz    = dz_ff;

   always_comb begin
      pmag = in_beat.prod[PROD_W-1] ? PROD_W'(-in_beat.prod) : PROD_W'(in_beat.prod);
      pq   = (pmag + (PROD_W'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
      up   = ({in_beat.rem, 1'b0} >= {1'b0, in_beat.den});
      dq   = PROD_W'(in_beat.num) + PROD_W'(up);
      case (in_beat.op)
         OP_MUL:  res_in = sat_mag(pq, in_beat.prod[PROD_W-1]);
         OP_DIV:  res_in = in_beat.dz ? in_beat.res : sat_mag(dq, in_beat.neg);
         default: res_in = in_beat.res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         res_ff <= res_in;
         cmp_ff <= in_beat.cmp;
         dz_ff  <= in_beat.dz;
      end
   end

endmodule

@@ rtl/fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu
// Q24.8 fixed-point ALU: decode stage, a row of divide cells, output stage.
//
//   channel | ports                                   | dir
//   req     | req_valid/ready, opcode, operand_a/b    | in
//   rsp     | rsp_valid/ready, result_value, flags    | out
//
// One beat per cycle sustained while rsp_ready holds high; every beat passes
// decode, NUM_W (40) one-bit restoring divide cells and the output stage.
// Each stage holds its beat while the next one is full and stalled, so bubbles close up.
// Synchronous reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module fixed_point_alu (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fpa_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_compare_true,
   output logic                              rsp_divide_by_zero
);
   import fpa_pkg::*;

   logic     valid [NUM_W+1];
   logic     ready [NUM_W+1];
   beat_type beat  [NUM_W+1];

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_op     (req_opcode),
      .in_a      (req_operand_a),
      .in_b      (req_operand_b),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_beat  (beat[0])
   );

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_beat   (beat[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_beat  (beat[i+1])
      );
   end

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[NUM_W]),
      .in_ready  (ready[NUM_W]),
      .in_beat   (beat[NUM_W]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (rsp_result_value),
      .out_cmp   (rsp_compare_true),
      .out_dz    (rsp_divide_by_zero)
   );

endmodule
